// ===== rtl/dpt_pkg.sv =====
package dpt_pkg;

  localparam int unsigned CyclesW    = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AccW       = 9;
  localparam int unsigned CountdownW = 12;
  localparam int unsigned SelW       = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [AccW-1:0]       DivLimit       = 9'd255;
  localparam logic [ByteW-1:0]      CountMax       = 8'hff;
  localparam logic [CountdownW-1:0] CountdownReset = 12'd1024;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_WRITE_DIV = 2'd1,
    KIND_WRITE_CNT = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULO  = 2'd0,
    CFG_ENABLE  = 2'd1,
    CFG_CLK_SEL = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  // reload period chosen by the clock select
  function automatic logic [CountdownW-1:0] period_of(input logic [SelW-1:0] sel);
    logic [CountdownW-1:0] p;
    case (sel)
      2'd0:    p = 12'd1024;
      2'd1:    p = 12'd16;
      2'd2:    p = 12'd64;
      default: p = 12'd256;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/dpt_if.sv =====
interface dpt_in_if;
  logic                             valid;
  logic                             ready;
  dpt_pkg::kind_t                   kind;
  logic [dpt_pkg::CyclesW-1:0]      cycles;
  logic [dpt_pkg::ByteW-1:0]        write_value;

  modport source (output valid, kind, cycles, write_value, input ready);
  modport sink   (input valid, kind, cycles, write_value, output ready);
endinterface

interface dpt_out_if;
  logic                             valid;
  logic                             ready;
  logic [dpt_pkg::ByteW-1:0]        divider_value;
  logic [dpt_pkg::ByteW-1:0]        counter_value;
  logic                             overflow_irq;

  modport source (output valid, divider_value, counter_value, overflow_irq, input ready);
  modport sink   (input valid, divider_value, counter_value, overflow_irq, output ready);
endinterface

interface dpt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dpt_pkg::CfgIdxW-1:0]      index;
  logic [dpt_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/divider_and_programmable_timer_top.sv =====
// Divider and programmable timer. Each accepted item (tick, divider write, counter
// write or no-op) produces exactly one result in the output register in the next
// cycle, and a new item is taken every cycle as long as the result register is empty
// or being drained in the same cycle; the rate is one item per clock, as the state of
// accumulator, countdown and counter is updated for every accepted item. Configuration
// writes are always taken and apply to the next item.
module divider_and_programmable_timer_top (
  input  logic       clk,
  input  logic       rst_n,
  dpt_in_if.sink     in_if,
  dpt_out_if.source  out_if,
  dpt_cfg_if.sink    cfg_if
);

  logic [dpt_pkg::ByteW-1:0]      modulo_r;
  logic                           enable_r;
  logic [dpt_pkg::SelW-1:0]       sel_r;

  logic [dpt_pkg::AccW-1:0]       acc_r, acc_nxt;
  logic [dpt_pkg::ByteW-1:0]      div_r, div_nxt;
  logic [dpt_pkg::CountdownW-1:0] cd_r, cd_nxt;
  logic [dpt_pkg::ByteW-1:0]      cnt_r, cnt_nxt;
  logic                           irq_nxt;

  logic                           out_valid_r;
  logic [dpt_pkg::ByteW-1:0]      out_div_r, out_cnt_r;
  logic                           out_irq_r;

  logic                           in_xfer;
  logic [dpt_pkg::AccW-1:0]       acc_sum;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulo_r <= '0;
      enable_r <= 1'b0;
      sel_r    <= '0;
    end else if (cfg_if.valid) begin
      case (dpt_pkg::cfg_idx_t'(cfg_if.index))
        dpt_pkg::CFG_MODULO:  modulo_r <= cfg_if.data;
        dpt_pkg::CFG_ENABLE:  enable_r <= cfg_if.data[0];
        dpt_pkg::CFG_CLK_SEL: sel_r    <= cfg_if.data[dpt_pkg::SelW-1:0];
        default: ;
      endcase
    end
  end

  assign acc_sum = acc_r + {{(dpt_pkg::AccW-dpt_pkg::CyclesW){1'b0}}, in_if.cycles};

  always_comb begin
    acc_nxt = acc_r;
    div_nxt = div_r;
    cd_nxt  = cd_r;
    cnt_nxt = cnt_r;
    irq_nxt = 1'b0;
    case (in_if.kind)
      dpt_pkg::KIND_TICK: begin
        if (acc_sum >= dpt_pkg::DivLimit) begin
          acc_nxt = '0;
          div_nxt = div_r + 8'd1;
        end else begin
          acc_nxt = acc_sum;
        end
        if (enable_r) begin
          if (cd_r <= {{(dpt_pkg::CountdownW-dpt_pkg::CyclesW){1'b0}}, in_if.cycles}) begin
            // reload drops the excess cycles
            cd_nxt = dpt_pkg::period_of(sel_r);
            if (cnt_r == dpt_pkg::CountMax) begin
              cnt_nxt = modulo_r;
              irq_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_r + 8'd1;
            end
          end else begin
            cd_nxt = cd_r - {{(dpt_pkg::CountdownW-dpt_pkg::CyclesW){1'b0}}, in_if.cycles};
          end
        end
      end
      dpt_pkg::KIND_WRITE_DIV: div_nxt = '0;
      dpt_pkg::KIND_WRITE_CNT: cnt_nxt = in_if.write_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      div_r       <= '0;
      cd_r        <= dpt_pkg::CountdownReset;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        acc_r       <= acc_nxt;
        div_r       <= div_nxt;
        cd_r        <= cd_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_div_r <= div_nxt;
      out_cnt_r <= cnt_nxt;
      out_irq_r <= irq_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.divider_value = out_div_r;
  assign out_if.counter_value = out_cnt_r;
  assign out_if.overflow_irq  = out_irq_r;

`ifndef SYNTH
  a_cd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cd_r != '0) && (cd_r <= dpt_pkg::CountdownReset))
    else $error("period countdown out of range");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r < dpt_pkg::DivLimit)
    else $error("divider accumulator not cleared at limit");

  a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_if.kind == dpt_pkg::KIND_WRITE_DIV) |=>
      out_if.valid && (out_if.divider_value == '0))
    else $error("divider write did not clear divider");
`endif

endmodule
